[rtl/core/bsm_pkg.sv]
// ----------------------------------------------------------------------------
// bsm_pkg: shared types and codes for the bank switching mapper
// Bus event and result transfer structs, function and target codes, register
// indexes and address map constants.
// ----------------------------------------------------------------------------
package bsm_pkg;

	localparam int PHYS_ADDR_BITS_DEF = 21;
	localparam int MEM_ADDR_W         = 21;
	localparam int WORK_RAM_BYTES     = 8192;

	// bus event codes
	localparam logic [2:0] FUNC_CPU_RD = 3'd0;
	localparam logic [2:0] FUNC_CPU_WR = 3'd1;
	localparam logic [2:0] FUNC_PPU_RD = 3'd2;
	localparam logic [2:0] FUNC_PPU_WR = 3'd3;
	localparam logic [2:0] FUNC_TICK   = 3'd4;

	// target memories
	localparam logic [2:0] TGT_NONE = 3'd0;
	localparam logic [2:0] TGT_PRG  = 3'd1;
	localparam logic [2:0] TGT_WRAM = 3'd2;
	localparam logic [2:0] TGT_CHR  = 3'd3;
	localparam logic [2:0] TGT_CRAM = 3'd4;

	// configuration register indexes
	localparam logic [1:0] CFG_PRG_UNITS  = 2'd0;
	localparam logic [1:0] CFG_CHR_UNITS  = 2'd1;
	localparam logic [1:0] CFG_INIT_MIRR  = 2'd2;

	// CPU address map
	localparam logic [15:0] WRAM_BASE = 16'h6000;
	localparam logic [15:0] REG_BASE  = 16'h8000;

	// register windows, selected by CPU address bits 14:13
	localparam logic [1:0] WIN_8000 = 2'd0;
	localparam logic [1:0] WIN_A000 = 2'd1;
	localparam logic [1:0] WIN_C000 = 2'd2;
	localparam logic [1:0] WIN_E000 = 2'd3;

	localparam logic [2:0] PRG_BANK_SEL = 3'b110;
	localparam logic [7:0] CHR_2K_MASK  = 8'hFE;

	typedef struct packed {
		logic [2:0]  func;
		logic [15:0] bus_addr;
		logic [7:0]  wdata;
	} req_t;

	typedef struct packed {
		logic [2:0]            target;
		logic [MEM_ADDR_W-1:0] mem_addr;
		logic                  mem_write;
		logic                  irq_fire;
		logic                  mirror_horizontal;
	} rsp_t;

endpackage

[rtl/core/bank_switch_mapper_scanline_irq.sv]
// ----------------------------------------------------------------------------
// bank_switch_mapper_scanline_irq: cartridge mapper with scanline IRQ counter
// Maps CPU/PPU accesses to program ROM, work RAM, character ROM or RAM,
// holds the bank registers and steps the scanline interrupt counter.
// ----------------------------------------------------------------------------
// Usage
//   req channel: one bus event per transfer (CPU rd/wr, PPU rd/wr, scanline
//   tick). rsp channel: exactly one result per event, in order. Both use
//   valid/stall; a transfer happens when valid is high and stall is low.
//   cfg channel: valid/ready register writes, always ready. Write sizes and
//   initial mirroring only while no event is in flight.
// Output: the result of an event is registered before it is shown on rsp.
// Throughput: one event per cycle while req_stall is low. The mapping and
//   register update are one level of logic between the request port and the
//   result register; the only thing that limits the rate is the receiver.
// Stall: a two-entry output (result register plus skid register) decouples
//   the sides. req_stall is registered: it rises only once the skid entry is
//   full, i.e. after rsp has been stalled with a result waiting behind it.
// Reset: bank registers, IRQ state and output queue clear; program size
//   resets to two 16 KB units, character RAM, vertical mirroring.
// ----------------------------------------------------------------------------
module bank_switch_mapper_scanline_irq #(
	parameter int PHYS_ADDR_BITS = bsm_pkg::PHYS_ADDR_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	// bus event channel
	input  logic          req_valid,
	output logic          req_stall,
	input  bsm_pkg::req_t req,
	// result channel
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output bsm_pkg::rsp_t rsp,
	// configuration channel
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [1:0]    cfg_index,
	input  logic [7:0]    cfg_data
);
	import bsm_pkg::*;

	localparam logic [MEM_ADDR_W-1:0] ADDR_MASK =
		MEM_ADDR_W'((64'd1 << PHYS_ADDR_BITS) - 64'd1);
	localparam logic [15:0] WRAM_MASK = 16'(WORK_RAM_BYTES - 1);

	// configuration registers; initial mirroring loads mirror_q directly
	logic [7:0] prg_units_q;
	logic [5:0] chr_units_q;

	// mapper state
	logic [2:0] bank_select_q;
	logic       prg_swapped_q;
	logic       chr_swapped_q;
	logic [7:0] bank_q [8];
	logic       mirror_q;
	logic [7:0] irq_reload_q;
	logic [7:0] irq_count_q;
	logic       irq_pending_q;
	logic       irq_enabled_q;

	// output queue
	logic       out_valid_q;
	rsp_t       out_q;
	logic       skid_valid_q;
	rsp_t       skid_q;

	logic       acc;
	logic       take;
	logic       cfg_wr;

	// decode of the current event
	logic       is_wram;
	logic       is_reg;
	logic       reg_wr;
	logic       odd;
	logic [1:0] win;
	logic [7:0] last_bank;
	logic [7:0] second_bank;
	logic [7:0] chr_mask;
	logic [7:0] bank_mask;
	logic [7:0] prg_bank;
	logic [12:0] chr_e;
	logic [2:0] chr_idx;
	logic [10:0] chr_off;
	logic [17:0] chr_addr;
	logic       chr_ram;
	logic       tick;
	logic       irq_zero;
	logic       mirror_d;
	rsp_t       rsp_d;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid & cfg_ready;

	assign take      = out_valid_q & ~rsp_stall;
	assign req_stall = skid_valid_q;
	assign acc       = req_valid & ~skid_valid_q;
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	// --- address decode -----------------------------------------------------
	assign is_wram = (req.bus_addr >= WRAM_BASE) && (req.bus_addr < REG_BASE);
	assign is_reg  = req.bus_addr >= REG_BASE;
	assign reg_wr  = acc && (req.func == FUNC_CPU_WR) && is_reg;
	assign odd     = req.bus_addr[0];
	assign win     = req.bus_addr[14:13];
	assign chr_ram = chr_units_q == 6'd0;
	assign tick    = acc && (req.func == FUNC_TICK);
	assign irq_zero = irq_count_q == 8'd0;

	// bank masks wrap at 8 bits, so odd sizes still give a defined mask
	assign last_bank   = 8'({prg_units_q[6:0], 1'b0} - 8'd1);
	assign second_bank = 8'(last_bank - 8'd1);
	assign chr_mask    = 8'({chr_units_q[4:0], 3'b000} - 8'd1);

	always_comb begin
		if ((bank_select_q & PRG_BANK_SEL) == PRG_BANK_SEL) begin
			bank_mask = last_bank;
		end else if (bank_select_q < 3'd2) begin
			bank_mask = chr_mask & CHR_2K_MASK;
		end else begin
			bank_mask = chr_mask;
		end
	end

	// program windows: 8000/C000 exchange when prg_swapped
	always_comb begin
		case (win)
			WIN_8000: prg_bank = prg_swapped_q ? second_bank : bank_q[6];
			WIN_A000: prg_bank = bank_q[7];
			WIN_C000: prg_bank = prg_swapped_q ? bank_q[6] : second_bank;
			default:  prg_bank = last_bank;
		endcase
	end

	// character windows: 2x2 KB then 4x1 KB, halves exchanged by chr_swapped
	assign chr_e = req.bus_addr[12:0] ^ {chr_swapped_q, 12'd0};
	always_comb begin
		if (!chr_e[12]) begin
			chr_idx = {2'b00, chr_e[11]};
			chr_off = chr_e[10:0];
		end else begin
			chr_idx = 3'd2 + {1'b0, chr_e[11:10]};
			chr_off = {1'b0, chr_e[9:0]};
		end
	end
	assign chr_addr = {bank_q[chr_idx], 10'd0} + 18'(chr_off);

	// mirroring seen by this result includes a write made by this event
	assign mirror_d = (reg_wr && (win == WIN_A000) && !odd) ? req.wdata[0] : mirror_q;

	// --- result -------------------------------------------------------------
	always_comb begin
		rsp_d                   = '0;
		rsp_d.target            = TGT_NONE;
		rsp_d.mirror_horizontal = mirror_d;
		case (req.func)
			FUNC_CPU_RD, FUNC_CPU_WR: begin
				if (is_wram) begin
					rsp_d.target    = TGT_WRAM;
					rsp_d.mem_addr  = MEM_ADDR_W'(16'(req.bus_addr - WRAM_BASE) & WRAM_MASK);
					rsp_d.mem_write = req.func == FUNC_CPU_WR;
				end else if (is_reg && (req.func == FUNC_CPU_RD)) begin
					rsp_d.target   = TGT_PRG;
					rsp_d.mem_addr = MEM_ADDR_W'({prg_bank, req.bus_addr[12:0]});
				end
			end
			FUNC_PPU_RD: begin
				if (chr_ram) begin
					rsp_d.target   = TGT_CRAM;
					rsp_d.mem_addr = MEM_ADDR_W'(req.bus_addr[12:0]);
				end else begin
					rsp_d.target   = TGT_CHR;
					rsp_d.mem_addr = MEM_ADDR_W'(chr_addr);
				end
			end
			FUNC_PPU_WR: begin
				// writes to character ROM are dropped
				if (chr_ram) begin
					rsp_d.target    = TGT_CRAM;
					rsp_d.mem_addr  = MEM_ADDR_W'(req.bus_addr[12:0]);
					rsp_d.mem_write = 1'b1;
				end
			end
			FUNC_TICK: begin
				rsp_d.irq_fire = irq_zero & irq_enabled_q;
			end
			default: begin
			end
		endcase
		rsp_d.mem_addr = rsp_d.mem_addr & ADDR_MASK;
	end

	// --- configuration ------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_units_q   <= 8'd2;
			chr_units_q   <= 6'd0;
		end else if (cfg_wr) begin
			case (cfg_index)
				CFG_PRG_UNITS: prg_units_q   <= cfg_data;
				CFG_CHR_UNITS: chr_units_q   <= cfg_data[5:0];
				default: begin
				end
			endcase
		end
	end

	// --- mapper registers ---------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_select_q <= '0;
			prg_swapped_q <= 1'b0;
			chr_swapped_q <= 1'b0;
			bank_q        <= '{default: 8'd0};
			mirror_q      <= 1'b0;
			irq_reload_q  <= '0;
			irq_enabled_q <= 1'b0;
		end else begin
			if (cfg_wr && (cfg_index == CFG_INIT_MIRR)) begin
				mirror_q <= cfg_data[0];
			end
			if (reg_wr) begin
				case (win)
					WIN_8000: begin
						if (!odd) begin
							prg_swapped_q <= req.wdata[6];
							chr_swapped_q <= req.wdata[7];
							bank_select_q <= req.wdata[2:0];
						end else begin
							bank_q[bank_select_q] <= req.wdata & bank_mask;
						end
					end
					WIN_A000: begin
						// odd address is RAM protect: ignored
						if (!odd) begin
							mirror_q <= req.wdata[0];
						end
					end
					WIN_C000: begin
						if (!odd) begin
							irq_reload_q <= req.wdata;
						end
					end
					default: begin
						irq_enabled_q <= odd;
					end
				endcase
			end
		end
	end

	// --- scanline counter ---------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			irq_count_q   <= '0;
			irq_pending_q <= 1'b0;
		end else begin
			if (tick) begin
				if (irq_zero || irq_pending_q) begin
					irq_pending_q <= 1'b0;
					irq_count_q   <= irq_reload_q;
				end else begin
					irq_count_q <= irq_count_q - 8'd1;
				end
			end else if (reg_wr && (win == WIN_C000) && odd) begin
				irq_pending_q <= 1'b1;
			end
		end
	end

	// --- output register and skid -------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (take) begin
					skid_valid_q <= 1'b0;
				end
			end else if (acc) begin
				if (!out_valid_q || take) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end else if (take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (acc) begin
			if (!out_valid_q || take) begin
				out_q <= rsp_d;
			end else begin
				skid_q <= rsp_d;
			end
		end
	end

	// --- checks -------------------------------------------------------------
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held with empty result register");

	a_none_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_q.target == TGT_NONE)) |-> (out_q.mem_addr == '0))
		else $error("address given with no target");

	a_write_targets: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.mem_write) |->
			((out_q.target == TGT_WRAM) || (out_q.target == TGT_CRAM)))
		else $error("write to a read-only or absent target");

	a_fire_no_access: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.irq_fire) |->
			((out_q.target == TGT_NONE) && !out_q.mem_write))
		else $error("irq pulse on a memory access");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(tick && !irq_zero && !irq_pending_q) |=>
			(irq_count_q == 8'($past(irq_count_q) - 8'd1)))
		else $error("scanline counter failed to step down");

endmodule

[tb/sv/bsm_tb_pkg.sv]
// ----------------------------------------------------------------------------
// bsm_tb_pkg: result predictor and scoreboard for the mapper testbench
// Keeps its own copy of the mapper registers and IRQ counter, works out the
// result of every accepted bus event and checks results against it in order.
// ----------------------------------------------------------------------------
package bsm_tb_pkg;
	import bsm_pkg::*;

	// bank registers that hold program banks
	localparam int PRG_SWAP_BANK = 6;
	localparam int PRG_A000_BANK = 7;

	class mapper_scoreboard;
		logic [7:0] prg_units;
		logic [5:0] chr_units;
		logic [2:0] bank_select;
		logic       prg_swapped;
		logic       chr_swapped;
		logic [7:0] bank_num [8];
		logic       mirror_mode;
		logic [7:0] irq_reload;
		logic [7:0] irq_count;
		logic       reload_pending;
		logic       irq_enabled;
		rsp_t       expected_rsp [$];
		int         fails;
		int         reported;

		function new();
			prg_units = 8'd2;
			chr_units = '0;
			bank_select = '0;
			prg_swapped = 1'b0;
			chr_swapped = 1'b0;
			foreach (bank_num[i])
				bank_num[i] = '0;
			mirror_mode = 1'b0;
			irq_reload = '0;
			irq_count = '0;
			reload_pending = 1'b0;
			irq_enabled = 1'b0;
			fails = 0;
			reported = 0;
		endfunction

		function void set_config(logic [1:0] idx, logic [7:0] data);
			case (idx)
				CFG_PRG_UNITS: prg_units = data;
				CFG_CHR_UNITS: chr_units = data[5:0];
				CFG_INIT_MIRR: mirror_mode = data[0];
				default: ;
			endcase
		endfunction

		// sizes wrap at 8 bits, so zero and odd sizes give odd masks
		function logic [7:0] prg_top_bank();
			return {prg_units[6:0], 1'b0} - 8'd1;
		endfunction

		function logic [7:0] chr_bank_mask();
			return {chr_units[4:0], 3'b000} - 8'd1;
		endfunction

		function logic [20:0] prg_offset(logic [15:0] a);
			logic [7:0] top;
			logic [7:0] bank;
			top = prg_top_bank();
			case (a[14:13])
				WIN_8000: bank = prg_swapped ? top - 8'd1 : bank_num[PRG_SWAP_BANK];
				WIN_A000: bank = bank_num[PRG_A000_BANK];
				WIN_C000: bank = prg_swapped ? bank_num[PRG_SWAP_BANK] : top - 8'd1;
				default:  bank = top;
			endcase
			return {bank, a[12:0]};
		endfunction

		function logic [20:0] chr_offset(logic [15:0] a);
			logic [12:0] v;
			v = a[12:0] ^ {chr_swapped, 12'h000};
			if (!v[12])
				return 21'(bank_num[int'(v[11])]) * 21'h400 + 21'(v[10:0]);
			return 21'(bank_num[2 + int'(v[11:10])]) * 21'h400 + 21'(v[9:0]);
		endfunction

		function void write_register(logic [15:0] a, logic [7:0] v);
			logic [7:0] m;
			case (a[14:13])
				WIN_8000: begin
					if (!a[0]) begin
						prg_swapped = v[6];
						chr_swapped = v[7];
						bank_select = v[2:0];
					end else if ((bank_select & PRG_BANK_SEL) == PRG_BANK_SEL) begin
						bank_num[bank_select] = v & prg_top_bank();
					end else begin
						m = chr_bank_mask();
						if (bank_select < 3'd2)
							m = m & CHR_2K_MASK;
						bank_num[bank_select] = v & m;
					end
				end
				WIN_A000: begin
					if (!a[0])
						mirror_mode = v[0];
				end
				WIN_C000: begin
					if (!a[0])
						irq_reload = v;
					else
						reload_pending = 1'b1;
				end
				default: irq_enabled = a[0];
			endcase
		endfunction

		function void note_request(req_t r);
			rsp_t e;
			e = '0;
			case (r.func)
				FUNC_CPU_RD, FUNC_CPU_WR: begin
					if (r.bus_addr >= WRAM_BASE && r.bus_addr < REG_BASE) begin
						e.target = TGT_WRAM;
						e.mem_addr = 21'(r.bus_addr[12:0]);
						e.mem_write = (r.func == FUNC_CPU_WR);
					end else if (r.bus_addr >= REG_BASE) begin
						if (r.func == FUNC_CPU_RD) begin
							e.target = TGT_PRG;
							e.mem_addr = prg_offset(r.bus_addr);
						end else begin
							write_register(r.bus_addr, r.wdata);
						end
					end
				end
				FUNC_PPU_RD: begin
					if (chr_units == '0) begin
						e.target = TGT_CRAM;
						e.mem_addr = 21'(r.bus_addr[12:0]);
					end else begin
						e.target = TGT_CHR;
						e.mem_addr = chr_offset(r.bus_addr);
					end
				end
				FUNC_PPU_WR: begin
					if (chr_units == '0) begin
						e.target = TGT_CRAM;
						e.mem_addr = 21'(r.bus_addr[12:0]);
						e.mem_write = 1'b1;
					end
				end
				FUNC_TICK: begin
					if (irq_count == '0 || reload_pending) begin
						reload_pending = 1'b0;
						e.irq_fire = (irq_count == '0) && irq_enabled;
						irq_count = irq_reload;
					end else begin
						irq_count = irq_count - 8'd1;
					end
				end
				default: ;
			endcase
			e.mirror_horizontal = mirror_mode;
			expected_rsp.push_back(e);
		endfunction

		function void check_result(rsp_t got);
			rsp_t e;
			if (expected_rsp.size() == 0) begin
				fails++;
				if (reported < 10)
					$display("unexpected result transfer: %p", got);
				reported++;
				return;
			end
			e = expected_rsp.pop_front();
			if (got.target !== e.target || got.mem_addr !== e.mem_addr ||
			    got.mem_write !== e.mem_write || got.irq_fire !== e.irq_fire ||
			    got.mirror_horizontal !== e.mirror_horizontal) begin
				fails++;
				if (reported < 10)
					$display("mismatch: target %0d/%0d addr %h/%h wr %b/%b irq %b/%b mirr %b/%b",
					         e.target, got.target, e.mem_addr, got.mem_addr,
					         e.mem_write, got.mem_write, e.irq_fire, got.irq_fire,
					         e.mirror_horizontal, got.mirror_horizontal);
				reported++;
			end
		endfunction

		function int pending();
			return expected_rsp.size();
		endfunction
	endclass

endpackage

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: bank switching mapper with scanline IRQ
// Drives bus events through the mapper under several size and mirroring
// settings and idle patterns, predicts every result and checks it in order.
// ----------------------------------------------------------------------------
module testbench;
	import bsm_pkg::*;
	import bsm_tb_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int HOLD_CYCLES = 150;
	localparam int PHASE_ITEMS = 230;
	localparam int PHASES      = 8;
	// index with no register behind it, written once to show it is ignored
	localparam logic [1:0] CFG_SPARE = 2'd3;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       req_valid = 1'b0;
	logic       req_stall;
	req_t       req       = '0;
	logic       rsp_valid;
	logic       rsp_stall = 1'b0;
	rsp_t       rsp;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [7:0] cfg_data  = '0;

	// idling odds in percent, set per phase
	int send_idle_pct = 0;
	int stall_pct     = 0;

	// receiver hold-off: a toggle from the stimulus starts a counted stall
	logic hold_toggle = 1'b0;
	logic hold_seen   = 1'b0;
	int   hold_left   = 0;
	int   cycles      = 0;

	mapper_scoreboard sb;

	always #6 clk = ~clk;

	bank_switch_mapper_scanline_irq u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Monitor: both channels are sampled at the rising edge, before the
	// edge's own updates land, so a transfer is seen exactly once.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall)
				sb.note_request(req);
			if (rsp_valid && !rsp_stall)
				sb.check_result(rsp);
		end
	end

	// Receiver: random stall, or a long counted hold-off once asked for.
	// During the hold-off the mapper's two-entry output fills and it must
	// push back on the event channel.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			hold_seen <= 1'b0;
			hold_left <= 0;
		end else if (hold_toggle != hold_seen) begin
			hold_seen <= hold_toggle;
			hold_left <= HOLD_CYCLES;
			rsp_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic req_t ev(logic [2:0] f, logic [15:0] a, logic [7:0] d);
		req_t r;
		r.func = f;
		r.bus_addr = a;
		r.wdata = d;
		return r;
	endfunction

	// One event transfer. Valid only drops for an idle gap, never between
	// back-to-back events, and the payload holds while stalled.
	task automatic send(input req_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
	endtask

	// Leaves cfg_valid high so that writes can follow back to back.
	task automatic cfg_write(input logic [1:0] idx, input logic [7:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.set_config(idx, data);
	endtask

	task automatic configure(input logic [7:0] prg, input logic [7:0] chr,
	                         input logic [7:0] mirr, input bit spare);
		cfg_write(CFG_PRG_UNITS, prg);
		cfg_write(CFG_CHR_UNITS, chr);
		cfg_write(CFG_INIT_MIRR, mirr);
		if (spare)
			cfg_write(CFG_SPARE, 8'hFF);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Stop offering events until every predicted result has come back,
	// then give the output pipe a little slack. The first edge lets the
	// monitor note the last event before the count is read.
	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic set_mode(input idle_mode_e m);
		case (m)
			IDLE_SENDER: begin
				send_idle_pct = 83;
				stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				send_idle_pct = 0;
				stall_pct = 83;
			end
			IDLE_BOTH: begin
				send_idle_pct = 8;
				stall_pct = 8;
			end
			default: begin
				send_idle_pct = 0;
				stall_pct = 0;
			end
		endcase
	endtask

	// Short directed run, with character RAM and two 16 KB program units.
	task automatic run_directed();
		// CPU map edges: below work RAM, work RAM ends, program windows
		send(ev(FUNC_CPU_RD, 16'h0000, 8'h00));
		send(ev(FUNC_CPU_WR, 16'h5FFF, 8'hFF));
		send(ev(FUNC_CPU_RD, 16'h6000, 8'h00));
		send(ev(FUNC_CPU_WR, 16'h7FFF, 8'hA5));
		send(ev(FUNC_CPU_RD, 16'h8000, 8'h00));
		send(ev(FUNC_CPU_RD, 16'hFFFF, 8'h00));
		// bank select with both swaps, then fill the program banks
		send(ev(FUNC_CPU_WR, 16'h8000, 8'hC7));
		send(ev(FUNC_CPU_WR, 16'h8001, 8'hFF));
		send(ev(FUNC_CPU_WR, 16'h8000, 8'hC6));
		send(ev(FUNC_CPU_WR, 16'h8001, 8'hFF));
		send(ev(FUNC_CPU_RD, 16'h8000, 8'h00));
		send(ev(FUNC_CPU_RD, 16'hC000, 8'h00));
		send(ev(FUNC_CPU_RD, 16'hA000, 8'h00));
		// mirroring, then the ignored RAM-protect write
		send(ev(FUNC_CPU_WR, 16'hA000, 8'h01));
		send(ev(FUNC_CPU_WR, 16'hA001, 8'hFF));
		// IRQ: latch 1, reload, enable; fires on the reload tick and at zero
		send(ev(FUNC_CPU_WR, 16'hC000, 8'h01));
		send(ev(FUNC_CPU_WR, 16'hC001, 8'h00));
		send(ev(FUNC_CPU_WR, 16'hE001, 8'h00));
		send(ev(FUNC_TICK,   16'h0000, 8'h00));
		send(ev(FUNC_TICK,   16'h0000, 8'h00));
		send(ev(FUNC_TICK,   16'h0000, 8'h00));
		// disable without acknowledge, counter carries on silently
		send(ev(FUNC_CPU_WR, 16'hE000, 8'h00));
		send(ev(FUNC_TICK,   16'hFFFF, 8'hFF));
		// PPU: high address bits dropped, character RAM write
		send(ev(FUNC_PPU_RD, 16'hFFFF, 8'h00));
		send(ev(FUNC_PPU_WR, 16'h1234, 8'h5A));
		// unused codes
		send(ev(3'd5, 16'hFFFF, 8'hFF));
		send(ev(3'd7, 16'h8000, 8'hFF));
	endtask

	// One random event, or a bank select followed by its bank data.
	task automatic send_random(output int n);
		int          roll;
		logic [15:0] a;
		logic [7:0]  d;
		roll = $urandom_range(99);
		d = 8'($urandom);
		n = 1;
		if (roll < 24) begin
			a = ($urandom_range(9) < 7) ? 16'($urandom_range(16'hFFFF, 16'h6000))
			                            : 16'($urandom);
			send(ev(FUNC_CPU_RD, a, d));
		end else if (roll < 44) begin
			a = REG_BASE | 16'($urandom_range(16'h1FFF));
			a[0] = 1'b0;
			send(ev(FUNC_CPU_WR, a, d));
			a = REG_BASE | 16'($urandom_range(16'h1FFF));
			a[0] = 1'b1;
			send(ev(FUNC_CPU_WR, a, 8'($urandom)));
			n = 2;
		end else if (roll < 56) begin
			a = 16'($urandom_range(16'hFFFF, 16'hA000));
			// keep the IRQ latch small most of the time so the counter fires
			if (a[14:13] == WIN_C000 && !a[0] && $urandom_range(3) != 0)
				d = 8'($urandom_range(6));
			send(ev(FUNC_CPU_WR, a, d));
		end else if (roll < 62) begin
			send(ev(FUNC_CPU_WR, 16'($urandom_range(16'h7FFF)), d));
		end else if (roll < 84) begin
			a = ($urandom_range(7) != 0) ? 16'($urandom_range(16'h1FFF)) : 16'($urandom);
			send(ev((roll < 78) ? FUNC_PPU_RD : FUNC_PPU_WR, a, d));
		end else if (roll < 98) begin
			send(ev(FUNC_TICK, 16'($urandom), d));
		end else begin
			send(ev(3'($urandom_range(7, 5)), 16'($urandom), d));
		end
	endtask

	// Phase plan: sizes cover the extremes, zero and non-power-of-two
	// values; raw register bytes carry set upper bits on some phases.
	logic [7:0] ph_prg  [PHASES] = '{8'd2, 8'd8, 8'd1, 8'd128, 8'd0, 8'd255, 8'd4, 8'd3};
	logic [7:0] ph_chr  [PHASES] = '{8'd0, 8'd16, 8'd1, 8'd32, 8'hFF, 8'd0, 8'd8, 8'd5};
	logic [7:0] ph_mirr [PHASES] = '{8'd0, 8'd1, 8'd0, 8'hFF, 8'hFE, 8'd1, 8'd0, 8'd0};
	idle_mode_e ph_mode [PHASES] = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH,
	                                 IDLE_NONE, IDLE_RECEIVER, IDLE_BOTH, IDLE_SENDER};

	initial begin
		int         k;
		int         n;
		bit         paused;
		logic [7:0] prg;
		logic [7:0] chr;
		logic [7:0] mirr;
		sb = new();
		paused = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int p = 0; p < PHASES; p++) begin
			prg = ph_prg[p];
			chr = ph_chr[p];
			mirr = ph_mirr[p];
			if (p == 6) begin
				prg = 8'd1 << $urandom_range(7);
				chr = 8'($urandom_range(32));
				mirr = 8'($urandom);
			end
			// registers only change with nothing in flight
			drain();
			configure(prg, chr, mirr, p == 4);
			set_mode(ph_mode[p]);
			if (p == 0)
				run_directed();
			// long receiver hold-off while the sender keeps offering
			if (ph_mode[p] == IDLE_RECEIVER)
				hold_toggle <= ~hold_toggle;
			k = 0;
			while (k < PHASE_ITEMS) begin
				// one mid-phase pause until every result is back
				if (p == 3 && k >= 100 && !paused) begin
					drain();
					paused = 1'b1;
				end
				send_random(n);
				k += n;
			end
		end

		drain();
		repeat (6) @(posedge clk);
		if (sb.fails == 0 && sb.pending() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

[filelist.f]
rtl/core/bsm_pkg.sv
rtl/core/bank_switch_mapper_scanline_irq.sv
tb/sv/bsm_tb_pkg.sv
tb/sv/testbench.sv
